@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL of the multiset match block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ src/swmm_pkg.sv @@
// Shared types and constants of the sliding window multiset match block.
// Used by the channel interfaces and the top level; depends on nothing.
package swmm_pkg;

   localparam int ACTION_W = 2;
   localparam int VALUE_W  = 10;
   localparam int CFG_W    = 9;
   localparam int MATCH_W  = 9;
   localparam int GOOD_W   = 32;
   localparam int VALUE_PAD = 16;

   localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET = 9'd1;
   localparam logic [CFG_W-1:0] MIN_MATCHES_RESET   = 9'd1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_PUSH  = 2'd2
   } action_type;

   typedef enum logic [0:0] {
      CSR_WINDOW_LENGTH = 1'b0,
      CSR_MIN_MATCHES   = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_DROP_CNT,
      ST_DROP_UPD,
      ST_PUSH_UPD,
      ST_LOAD_UPD,
      ST_EMIT
   } state_type;

endpackage

@@ src/swmm_channels.sv @@
// Valid/ready channel interfaces of the multiset match block: request,
// response and register write. Depends on swmm_pkg.
interface swmm_req_if import swmm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [VALUE_W-1:0]  value;

   modport source (output valid, output action, output value, input ready);
   modport sink (input valid, input action, input value, output ready);
endinterface

interface swmm_rsp_if import swmm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               window_full;
   logic               window_good;
   logic [MATCH_W-1:0] matched_count;
   logic [GOOD_W-1:0]  good_windows;

   modport source (output valid, output window_full, output window_good,
                   output matched_count, output good_windows, input ready);
   modport sink (input valid, input window_full, input window_good,
                 input matched_count, input good_windows, output ready);
endinterface

interface swmm_csr_if import swmm_pkg::*; ();
   logic             valid;
   logic             ready;
   csr_index_type    index;
   logic [CFG_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/sliding_window_multiset_match.sv @@
// Sliding window multiset match counter, top level.
// Depends on swmm_pkg, the channel interfaces and assert_macros.svh.
//
// Requests arrive on req_chan: action clear, load a value into the reference
// multiset B, or push a stream value into the window. Every accepted request
// transaction gives exactly one response transaction on rsp_chan, carrying
// whether the window is full, whether this push made a good window, the
// matched count and the saturating good window count. Registers
// window_length and min_matches are written over csr_chan, which is always
// ready; write them only while the block is idle.
// Both count tables share one word per value in a memory with one read and
// one write port and a registered read; the window contents sit in a second
// memory used as a FIFO.
// A load goes via ST_LOAD_UPD, a push that drops nothing via ST_PUSH_UPD, to
// the response register. A push into a full window first passes ST_DROP_CNT
// and ST_DROP_UPD, again for each value dropped after a shrink of the window.
// After reset, and after a clear action, a sweep zeroes all 2**VALUE_BITS
// count memory entries, one per cycle; no request is taken during it.
// The response register lets the next request be accepted while a response
// waits; if the receiver stalls, the block holds the next finished response
// internally and takes no further request until it is passed on.
`include "assert_macros.svh"

module sliding_window_multiset_match import swmm_pkg::*; #(
   parameter int VALUE_BITS = 10,
   parameter int MAX_WINDOW = 256
) (
   input  logic        clock,
   input  logic        reset,
   swmm_req_if.sink    req_chan,
   swmm_rsp_if.source  rsp_chan,
   swmm_csr_if.sink    csr_chan
);

   localparam int VALUE_COUNT = 1 << VALUE_BITS;
   localparam int FILL_W  = $clog2(MAX_WINDOW + 1);
   localparam int HEAD_W  = $clog2(MAX_WINDOW);
   localparam int REF_W   = $clog2(2 * MAX_WINDOW);
   localparam int CMP_W   = (FILL_W > CFG_W) ? FILL_W : CFG_W;
   localparam int WORD_W  = REF_W + FILL_W;
   localparam int SLOT_W  = FILL_W + 1;
   localparam int REF_MAX = 2 * MAX_WINDOW - 1;

   // Memories: count word {reference count, window count} and window FIFO.
   logic [WORD_W-1:0]     tbl_mem [VALUE_COUNT];
   logic [VALUE_BITS-1:0] fifo_mem [MAX_WINDOW];

   state_type             state_ff, state_in;
   logic [CFG_W-1:0]      wl_ff, wl_in;
   logic [CFG_W-1:0]      mm_ff, mm_in;
   logic [VALUE_BITS-1:0] v_ff, v_in;
   logic [HEAD_W-1:0]     head_ff, head_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [FILL_W-1:0]     matched_ff, matched_in;
   logic [GOOD_W-1:0]     good_ff, good_in;
   logic [VALUE_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic                  good_pend_ff, good_pend_in;
   logic                  fwd_hit_ff, fwd_hit_in;
   logic [WORD_W-1:0]     fwd_word_ff, fwd_word_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_full_ff, rsp_full_in;
   logic                  rsp_good_ff, rsp_good_in;
   logic [MATCH_W-1:0]    rsp_match_ff, rsp_match_in;
   logic [GOOD_W-1:0]     rsp_windows_ff, rsp_windows_in;

   logic [WORD_W-1:0]     tbl_rd_ff;
   logic [VALUE_BITS-1:0] rd_addr_ff;
   logic [VALUE_BITS-1:0] fifo_rd_ff;

   logic [VALUE_W+VALUE_PAD-1:0] req_value_ext;
   logic [VALUE_BITS-1:0] req_v;
   logic                  req_fire, csr_fire, out_free;
   logic [CMP_W-1:0]      wl_wide, len_wide, fill_wide;
   logic                  need_drop, clr_last;

   logic [WORD_W-1:0]     tbl_word;
   logic [FILL_W-1:0]     word_wc;
   logic [REF_W-1:0]      word_rc;
   logic [FILL_W-1:0]     drop_wc, push_wc, fill_dec, fill_inc;
   logic [REF_W-1:0]      load_rc;
   logic                  drop_dec, more_drop, push_inc, load_ok, load_inc;
   logic                  good_hit, done_good;
   logic [HEAD_W-1:0]     head_next;

   logic                  tbl_we, fifo_we, fin, rsp_load, emit_good;
   logic [VALUE_BITS-1:0] tbl_raddr, tbl_waddr;
   logic [WORD_W-1:0]     tbl_wdata;
   logic [HEAD_W-1:0]     fifo_raddr;
   logic [SLOT_W-1:0]     slot_head, slot_fill, slot_diff;

   assign req_value_ext = {{VALUE_PAD{1'b0}}, req_chan.value};
   assign req_v         = req_value_ext[VALUE_BITS-1:0];
   assign req_fire      = req_chan.valid && req_chan.ready;
   assign csr_fire      = csr_chan.valid && csr_chan.ready;
   assign out_free      = !rsp_valid_ff || rsp_chan.ready;
   assign clr_last      = (clr_addr_ff == {VALUE_BITS{1'b1}});

   // Window length as used: zero acts as one, anything above the FIFO depth
   // acts as the depth.
   assign wl_wide   = CMP_W'(wl_ff);
   assign fill_wide = CMP_W'(fill_ff);
   always_comb begin
      if (wl_ff == '0) begin
         len_wide = CMP_W'(1);
      end else if (wl_wide > CMP_W'(MAX_WINDOW)) begin
         len_wide = CMP_W'(MAX_WINDOW);
      end else begin
         len_wide = wl_wide;
      end
   end
   assign need_drop = (fill_ff != '0) && (fill_wide >= len_wide);

   // Count word as read, with the word written in the previous cycle taking
   // precedence when it went to the same entry.
   assign tbl_word = fwd_hit_ff ? fwd_word_ff : tbl_rd_ff;
   assign word_wc  = tbl_word[FILL_W-1:0];
   assign word_rc  = tbl_word[WORD_W-1:FILL_W];

   assign drop_wc   = (word_wc != '0) ? word_wc - FILL_W'(1) : word_wc;
   assign drop_dec  = (word_wc != '0) && (REF_W'(drop_wc) < word_rc) && (matched_ff != '0);
   assign fill_dec  = fill_ff - FILL_W'(1);
   assign more_drop = (fill_dec != '0) && (CMP_W'(fill_dec) >= len_wide);
   assign push_inc  = REF_W'(word_wc) < word_rc;
   assign push_wc   = word_wc + FILL_W'(1);
   assign fill_inc  = fill_ff + FILL_W'(1);
   assign load_ok   = word_rc < REF_W'(REF_MAX);
   assign load_inc  = load_ok && (REF_W'(word_wc) > word_rc);
   assign load_rc   = load_ok ? word_rc + REF_W'(1) : word_rc;
   assign head_next = (head_ff == HEAD_W'(MAX_WINDOW - 1)) ? '0 : head_ff + HEAD_W'(1);

   // Datapath next values.
   always_comb begin
      wl_in       = wl_ff;
      mm_in       = mm_ff;
      v_in        = v_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      matched_in  = matched_ff;
      good_in     = good_ff;
      clr_addr_in = clr_addr_ff;
      good_hit    = 1'b0;

      if (csr_fire) begin
         if (csr_chan.index == CSR_WINDOW_LENGTH) begin
            wl_in = csr_chan.data;
         end else begin
            mm_in = csr_chan.data;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               v_in = req_v;
               if (req_chan.action == ACT_CLEAR) begin
                  head_in     = '0;
                  fill_in     = '0;
                  matched_in  = '0;
                  good_in     = '0;
                  clr_addr_in = '0;
               end
            end
         end
         ST_INIT, ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + VALUE_BITS'(1);
         end
         ST_DROP_UPD: begin
            fill_in    = fill_dec;
            matched_in = drop_dec ? matched_ff - FILL_W'(1) : matched_ff;
         end
         ST_PUSH_UPD: begin
            fill_in    = fill_inc;
            head_in    = head_next;
            matched_in = push_inc ? matched_ff + FILL_W'(1) : matched_ff;
            good_hit   = (CMP_W'(fill_inc) == len_wide)
                         && (CMP_W'(matched_in) >= CMP_W'(mm_ff));
            if (good_hit && (good_ff != {GOOD_W{1'b1}})) begin
               good_in = good_ff + GOOD_W'(1);
            end
         end
         ST_LOAD_UPD: begin
            matched_in = load_inc ? matched_ff + FILL_W'(1) : matched_ff;
         end
         default: begin
         end
      endcase
   end

   assign done_good = (state_ff == ST_PUSH_UPD) && good_hit;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_chan.action)
                  ACT_CLEAR: state_in = ST_CLEAR;
                  ACT_LOAD:  state_in = ST_LOAD_UPD;
                  ACT_PUSH:  state_in = need_drop ? ST_DROP_CNT : ST_PUSH_UPD;
                  default:   state_in = ST_EMIT;
               endcase
            end
         end
         ST_CLEAR: begin
            if (clr_last) state_in = out_free ? ST_IDLE : ST_EMIT;
         end
         ST_DROP_CNT: state_in = ST_DROP_UPD;
         ST_DROP_UPD: state_in = more_drop ? ST_DROP_CNT : ST_PUSH_UPD;
         ST_PUSH_UPD, ST_LOAD_UPD, ST_EMIT: begin
            state_in = out_free ? ST_IDLE : ST_EMIT;
         end
         default: state_in = ST_INIT;
      endcase
   end

   // Memory control and response loading.
   always_comb begin
      tbl_we    = 1'b0;
      tbl_waddr = rd_addr_ff;
      tbl_wdata = tbl_word;
      fifo_we   = 1'b0;
      fin       = 1'b0;
      emit_good = 1'b0;
      unique case (state_ff)
         ST_IDLE:     tbl_raddr = req_v;
         ST_DROP_CNT: tbl_raddr = fifo_rd_ff;
         default:     tbl_raddr = v_ff;
      endcase
      unique case (state_ff)
         ST_INIT: begin
            tbl_we    = 1'b1;
            tbl_waddr = clr_addr_ff;
            tbl_wdata = '0;
         end
         ST_CLEAR: begin
            tbl_we    = 1'b1;
            tbl_waddr = clr_addr_ff;
            tbl_wdata = '0;
            fin       = clr_last;
         end
         ST_DROP_UPD: begin
            tbl_we    = 1'b1;
            tbl_wdata = {word_rc, drop_wc};
         end
         ST_PUSH_UPD: begin
            tbl_we    = 1'b1;
            tbl_wdata = {word_rc, push_wc};
            fifo_we   = 1'b1;
            fin       = 1'b1;
            emit_good = done_good;
         end
         ST_LOAD_UPD: begin
            tbl_we    = 1'b1;
            tbl_wdata = {load_rc, word_wc};
            fin       = 1'b1;
         end
         ST_EMIT: begin
            fin       = 1'b1;
            emit_good = good_pend_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_load = fin && out_free;

   // Oldest FIFO slot for the fill level of the next cycle.
   assign slot_head  = SLOT_W'(head_ff);
   assign slot_fill  = SLOT_W'(fill_in);
   assign slot_diff  = (slot_head >= slot_fill) ? slot_head - slot_fill
                       : slot_head + SLOT_W'(MAX_WINDOW) - slot_fill;
   assign fifo_raddr = slot_diff[HEAD_W-1:0];

   assign fwd_hit_in   = tbl_we && (tbl_waddr == tbl_raddr);
   assign fwd_word_in  = tbl_wdata;
   // A newly accepted transaction starts with no good window pending.
   assign good_pend_in = (fin && !out_free) ? emit_good
                         : (req_fire ? 1'b0 : good_pend_ff);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_full_in    = rsp_full_ff;
      rsp_good_in    = rsp_good_ff;
      rsp_match_in   = rsp_match_ff;
      rsp_windows_in = rsp_windows_ff;
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_full_in    = (CMP_W'(fill_in) == len_wide);
         rsp_good_in    = emit_good;
         rsp_match_in   = MATCH_W'(matched_in);
         rsp_windows_in = good_in;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
      tbl_rd_ff  <= tbl_mem[tbl_raddr];
      rd_addr_ff <= tbl_raddr;
   end

   always_ff @(posedge clock) begin
      if (fifo_we) fifo_mem[head_ff] <= v_ff;
      fifo_rd_ff <= fifo_mem[fifo_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         wl_ff        <= WINDOW_LENGTH_RESET;
         mm_ff        <= MIN_MATCHES_RESET;
         head_ff      <= '0;
         fill_ff      <= '0;
         matched_ff   <= '0;
         good_ff      <= '0;
         clr_addr_ff  <= '0;
         good_pend_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wl_ff        <= wl_in;
         mm_ff        <= mm_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         matched_ff   <= matched_in;
         good_ff      <= good_in;
         clr_addr_ff  <= clr_addr_in;
         good_pend_ff <= good_pend_in;
         fwd_hit_ff   <= fwd_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff           <= v_in;
      fwd_word_ff    <= fwd_word_in;
      rsp_full_ff    <= rsp_full_in;
      rsp_good_ff    <= rsp_good_in;
      rsp_match_ff   <= rsp_match_in;
      rsp_windows_ff <= rsp_windows_in;
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign csr_chan.ready         = 1'b1;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.window_full   = rsp_full_ff;
   assign rsp_chan.window_good   = rsp_good_ff;
   assign rsp_chan.matched_count = rsp_match_ff;
   assign rsp_chan.good_windows  = rsp_windows_ff;

   `ASSERT_IMPLIES(a_fill_bound, clock, reset, 1'b1, fill_wide <= CMP_W'(MAX_WINDOW), "window fill level beyond FIFO depth")
   `ASSERT_IMPLIES(a_matched_le_fill, clock, reset, 1'b1, matched_ff <= fill_ff, "matched count exceeds window fill level")
   `ASSERT_IMPLIES(a_good_needs_full, clock, reset, rsp_chan.valid && rsp_chan.window_good, rsp_chan.window_full, "good window reported on a window that is not full")
   `ASSERT_NEXT(a_clear_ends, clock, reset, state_ff == ST_CLEAR && clr_last, state_ff == ST_IDLE || state_ff == ST_EMIT, "clearing sweep did not finish")

endmodule
